@@ rtl/triple_product_field_force_macros.svh @@
// assertion macros for the triple product field force block
`ifndef TRIPLE_PRODUCT_FIELD_FORCE_MACROS_SVH
`define TRIPLE_PRODUCT_FIELD_FORCE_MACROS_SVH

// checked every cycle outside reset
`define TPFF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence checked in the cycle after the antecedent, outside reset
`define TPFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// checked also while reset is high
`define TPFF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tpff_pkg.sv @@
// shared constants for the triple product field force block
package tpff_pkg;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MU    = 2'd0,
    REG_KAPPA = 2'd1,
    REG_MASS  = 2'd2,
    REG_INV   = 2'd3
  } reg_index_t;

  localparam logic [1:0] FIELD_ONE   = 2'd0;
  localparam logic [1:0] FIELD_TWO   = 2'd1;
  localparam logic [1:0] FIELD_THREE = 2'd2;

endpackage

@@ rtl/tpff_qmul.sv @@
// fixed point multiply with rounding to nearest and saturation, registered
module tpff_qmul #(
  parameter int AW         = 32,
  parameter int BW         = 32,
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [AW-1:0]         a,
  input  logic signed [BW-1:0]         b,
  output logic signed [DATA_WIDTH-1:0] y
);

  localparam int PW = AW + BW + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] MAXV = (PW'(1) << (DATA_WIDTH - 1)) - PW'(1);
  localparam logic [DATA_WIDTH-1:0] MAXD = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIND = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [AW-1:0]             ma;
  logic [BW-1:0]             mb;
  logic [AW+BW-1:0]          prod;
  logic [PW-1:0]             rnd;
  logic [PW-1:0]             sh;
  logic                      neg;
  logic [DATA_WIDTH-1:0]     y_next;

  always_comb begin
    ma   = a[AW-1] ? unsigned'(-a) : unsigned'(a);
    mb   = b[BW-1] ? unsigned'(-b) : unsigned'(b);
    prod = ma * mb;
    rnd  = {1'b0, prod} + HALF;
    sh   = rnd >> FRAC_BITS;
    neg  = a[AW-1] ^ b[BW-1];
    if (sh > MAXV) begin
      y_next = neg ? MIND : MAXD;
    end else begin
      y_next = neg ? -sh[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_next;
    end
  end

endmodule

@@ rtl/tpff_div.sv @@
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
module tpff_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24,
  parameter int SIDE_W     = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] quo,
  output logic [SIDE_W-1:0]            side_out
);

  localparam int DW = DATA_WIDTH;
  localparam int HW = FRAC_BITS + 1;
  localparam int NW = DW + HW;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam logic [DW-1:0] MAXD = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIND = {1'b1, {(DW-1){1'b0}}};

  logic              v_s    [DW+1];
  logic              neg_s  [DW+1];
  logic              ovf_s  [DW+1];
  logic [DW-1:0]     rem_s  [DW+1];
  logic [DW-1:0]     nlo_s  [DW+1];
  logic [DW-1:0]     q_s    [DW+1];
  logic [DW-1:0]     den_s  [DW+1];
  logic [SIDE_W-1:0] side_s [DW+1];

  logic [DW-1:0] mag0;
  logic [NW-1:0] nfull;
  logic [HW-1:0] nhi;
  logic          ovf0;

  // setup: magnitude, early overflow check, top numerator bits as remainder
  always_comb begin
    mag0  = num[DW-1] ? unsigned'(-num) : unsigned'(num);
    nfull = {mag0, {HW{1'b0}}};
    nhi   = nfull[NW-1:DW];
    ovf0  = CW'(nhi) >= CW'(unsigned'(den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s[0]  <= num[DW-1];
      ovf_s[0]  <= ovf0;
      rem_s[0]  <= DW'(nhi);
      nlo_s[0]  <= nfull[DW-1:0];
      q_s[0]    <= '0;
      den_s[0]  <= unsigned'(den);
      side_s[0] <= side_in;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
      trial = {rem_s[k], nlo_s[k][DW-1]};
      diff  = trial - {1'b0, den_s[k]};
      ge    = trial >= {1'b0, den_s[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_s[k+1]  <= neg_s[k];
        ovf_s[k+1]  <= ovf_s[k];
        rem_s[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nlo_s[k+1]  <= nlo_s[k] << 1;
        q_s[k+1]    <= {q_s[k][DW-2:0], ge};
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  logic [DW:0]   rq;
  logic          sat;
  logic [DW-1:0] quo_next;

  // half-unit rounding of the doubled quotient, with saturation
  always_comb begin
    rq  = ({1'b0, q_s[DW]} + (DW+1)'(1)) >> 1;
    sat = ovf_s[DW] || (&q_s[DW]);
    if (sat) begin
      quo_next = neg_s[DW] ? MIND : MAXD;
    end else begin
      quo_next = neg_s[DW] ? -rq[DW-1:0] : rq[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo      <= quo_next;
      side_out <= side_s[DW];
    end
  end

endmodule

@@ rtl/triple_product_field_force.sv @@
// triple product field force: top level with config registers and the pipeline
// One grid point enters per clock and one acceleration leaves per clock while
// the output is not held. The pipeline consists of six front stages (five of
// multiplies and one for the saturating base add), a divider that resolves one
// quotient bit per stage plus its setup and rounding stages, and the output
// register. The whole pipeline advances together: when the output is held,
// in_ready drops and nothing moves.
// Config registers may be written only while no item is in flight.
module triple_product_field_force #(
  parameter int FRAC_BITS  = 24,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [tpff_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  logic [DATA_WIDTH-1:0]                 wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            func,
  input  logic signed [DATA_WIDTH-1:0]          field_one,
  input  logic signed [DATA_WIDTH-1:0]          field_two,
  input  logic signed [DATA_WIDTH-1:0]          field_three,
  input  logic signed [DATA_WIDTH-1:0]          east_value,
  input  logic signed [DATA_WIDTH-1:0]          west_value,
  input  logic signed [DATA_WIDTH-1:0]          north_value,
  input  logic signed [DATA_WIDTH-1:0]          south_value,
  input  logic signed [DATA_WIDTH-1:0]          up_value,
  input  logic signed [DATA_WIDTH-1:0]          down_value,
  input  logic                                  on_boundary,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [DATA_WIDTH-1:0]          acceleration
);

  localparam int DW = DATA_WIDTH;
  localparam int SW = DW + 4;
  localparam int SIDE_W = 2 * DW + 1;

  localparam longint MAXV_L = (DW == 64) ? 64'sh7fff_ffff_ffff_ffff
                                         : ((longint'(1) <<< (DW - 1)) - 1);
  localparam longint MINV_L = -MAXV_L - 1;
  localparam longint UNIT_L = longint'(1) <<< FRAC_BITS;
  localparam longint MU_L   = (-10 * UNIT_L < MINV_L) ? MINV_L : -10 * UNIT_L;
  localparam longint KAP_L  = (10 * UNIT_L > MAXV_L) ? MAXV_L : 10 * UNIT_L;
  localparam longint ONE_L  = (UNIT_L > MAXV_L) ? MAXV_L : UNIT_L;
  localparam longint INV_L  = (longint'(184554409) > MAXV_L) ? MAXV_L
                                                             : longint'(184554409);

  localparam logic [DW-1:0] MU_RST   = DW'(MU_L);
  localparam logic [DW-2:0] KAP_RST  = (DW-1)'(KAP_L);
  localparam logic [DW-2:0] MASS_RST = (DW-1)'(ONE_L);
  localparam logic [DW-2:0] INV_RST  = (DW-1)'(INV_L);
  localparam logic [DW:0]   ONE_X    = (DW+1)'(ONE_L);
  localparam logic [DW-1:0] MAXD     = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIND     = {1'b1, {(DW-1){1'b0}}};

  logic en;

  // config registers
  logic signed [DW-1:0] coupling_mu;
  logic [DW-2:0]        saturation_kappa;
  logic [DW-2:0]        mass_squared;
  logic [DW-2:0]        inv_spacing_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_mu      <= MU_RST;
      saturation_kappa <= KAP_RST;
      mass_squared     <= MASS_RST;
      inv_spacing_sq   <= INV_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        tpff_pkg::REG_MU:    coupling_mu      <= wr_data;
        tpff_pkg::REG_KAPPA: saturation_kappa <= wr_data[DW-2:0];
        tpff_pkg::REG_MASS:  mass_squared     <= wr_data[DW-2:0];
        tpff_pkg::REG_INV:   inv_spacing_sq   <= wr_data[DW-2:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: pair products, laplacian sum, mass term
  logic signed [DW-1:0] c_sel;
  logic signed [SW-1:0] sum_next;

  always_comb begin
    case (func)
      tpff_pkg::FIELD_ONE: c_sel = field_one;
      tpff_pkg::FIELD_TWO: c_sel = field_two;
      default:             c_sel = field_three;
    endcase
    sum_next = SW'(east_value) + SW'(west_value) + SW'(north_value)
             + SW'(south_value) + SW'(up_value) + SW'(down_value)
             - (SW'(c_sel) <<< 2) - (SW'(c_sel) <<< 1);
  end

  logic                 v1, v2, v3, v4, v5, v6;
  logic                 bnd1, bnd2, bnd3, bnd4, bnd5, bnd6;
  logic [1:0]           sel1;
  logic signed [DW-1:0] f3_1;
  logic signed [SW-1:0] sum1;
  logic signed [DW-1:0] q12, q13, q23, mc1;

  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_q12 (
    .clk(clk), .en(en), .a(field_one), .b(field_two), .y(q12));
  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_q13 (
    .clk(clk), .en(en), .a(field_one), .b(field_three), .y(q13));
  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_q23 (
    .clk(clk), .en(en), .a(field_two), .b(field_three), .y(q23));
  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_mc (
    .clk(clk), .en(en), .a({1'b0, mass_squared}), .b(c_sel), .y(mc1));

  // stage 2: full product, selected partial product, laplacian
  logic signed [DW-1:0] p2, dp2, lap2, mc2;

  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_p (
    .clk(clk), .en(en), .a(q12), .b(f3_1), .y(p2));
  tpff_qmul #(.AW(SW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_lap (
    .clk(clk), .en(en), .a(sum1), .b({1'b0, inv_spacing_sq}), .y(lap2));

  // stage 3: square and mu product
  logic signed [DW-1:0] pp3, mup3, dp3, lap3, mc3;

  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_pp (
    .clk(clk), .en(en), .a(p2), .b(p2), .y(pp3));
  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_mup (
    .clk(clk), .en(en), .a(coupling_mu), .b(p2), .y(mup3));

  // stage 4: kappa term and numerator
  logic signed [DW-1:0] kq4, num4, lap4, mc4;

  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_kq (
    .clk(clk), .en(en), .a({1'b0, saturation_kappa}), .b(pp3), .y(kq4));
  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_num (
    .clk(clk), .en(en), .a(mup3), .b(dp3), .y(num4));

  // stage 5: base = one + kappa term, saturated
  logic [DW:0]          base_sum;
  logic [DW-1:0]        base_next;
  logic signed [DW-1:0] base5, num5, lap5, mc5;

  always_comb begin
    base_sum = {kq4[DW-1], kq4} + ONE_X;
    if (base_sum[DW] != base_sum[DW-1]) begin
      base_next = base_sum[DW] ? MIND : MAXD;
    end else begin
      base_next = base_sum[DW-1:0];
    end
  end

  // stage 6: denominator
  logic signed [DW-1:0] den6, num6, lap6, mc6;

  tpff_qmul #(.AW(DW), .BW(DW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_den (
    .clk(clk), .en(en), .a(base5), .b(base5), .y(den6));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bnd1  <= on_boundary;
      sel1  <= func;
      f3_1  <= field_three;
      sum1  <= sum_next;
      bnd2  <= bnd1;
      case (sel1)
        tpff_pkg::FIELD_ONE: dp2 <= q23;
        tpff_pkg::FIELD_TWO: dp2 <= q13;
        default:             dp2 <= q12;
      endcase
      mc2   <= mc1;
      bnd3  <= bnd2;
      dp3   <= dp2;
      lap3  <= lap2;
      mc3   <= mc2;
      bnd4  <= bnd3;
      lap4  <= lap3;
      mc4   <= mc3;
      bnd5  <= bnd4;
      base5 <= base_next;
      num5  <= num4;
      lap5  <= lap4;
      mc5   <= mc4;
      bnd6  <= bnd5;
      num6  <= num5;
      lap6  <= lap5;
      mc6   <= mc5;
    end
  end

  // force division
  logic signed [DW-1:0] den_fix;
  logic                 dv;
  logic signed [DW-1:0] force_q;
  logic [SIDE_W-1:0]    side_q;

  assign den_fix = (den6 <= 0) ? DW'(1) : den6;

  tpff_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v6),
    .num(num6),
    .den(den_fix),
    .side_in({bnd6, lap6, mc6}),
    .out_valid(dv),
    .quo(force_q),
    .side_out(side_q)
  );

  // final sum and saturation, zero on boundary points
  logic signed [DW+1:0] acc_sum;
  logic [DW-1:0]        acc_next;

  always_comb begin
    acc_sum = (DW+2)'($signed(side_q[2*DW-1:DW])) - (DW+2)'($signed(side_q[DW-1:0]))
            - (DW+2)'(force_q);
    if (side_q[2*DW]) begin
      acc_next = '0;
    end else if (acc_sum > (DW+2)'($signed(MAXD))) begin
      acc_next = MAXD;
    end else if (acc_sum < (DW+2)'($signed(MIND))) begin
      acc_next = MIND;
    end else begin
      acc_next = acc_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acceleration <= acc_next;
    end
  end

endmodule

@@ rtl/tpff_checker.sv @@
// port level checks for the triple product field force block
`include "triple_product_field_force_macros.svh"

module tpff_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] acceleration
);

  `TPFF_ASSERT_ALWAYS(a_rst_clears, rst, !out_valid, "output valid after reset")
  `TPFF_ASSERT_IMPL(a_ready_follows, 1'b1, in_ready == (!out_valid || out_ready), "ready mismatch")
  `TPFF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(acceleration), "stalled item changed")

endmodule

bind triple_product_field_force tpff_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tpff_checker (.*);
